// ===== rtl/bezier_curve_flattener_defines.svh =====
// ----------------------------------------------------------------------------
// Bezier curve flattener assertion macros
// Shared property forms for the checker of the flattener.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_FLATTENER_DEFINES_SVH
`define BEZIER_CURVE_FLATTENER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BCF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BCF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bcf_pkg.sv =====
// ----------------------------------------------------------------------------
// bcf_pkg
// Word types and fixed constants of the Bezier curve flattener.
// ----------------------------------------------------------------------------
`default_nettype none

package bcf_pkg;

    // Q16.8 coordinate and integer pixel widths
    localparam int COORD_W    = 24;
    localparam int PIX_W      = 16;
    localparam int PIX_FRAC   = 8;
    localparam int SEG_IDX_W  = 7;
    localparam int MIN_POINTS = 2;

    // Status codes of a result word
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FEW  = 2'd1;
    localparam logic [1:0] STATUS_DROP = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_point;
    } bcf_in_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] start_x;
        logic signed [PIX_W-1:0] start_y;
        logic signed [PIX_W-1:0] end_x;
        logic signed [PIX_W-1:0] end_y;
        logic [SEG_IDX_W-1:0]    segment_index;
        logic                    final_segment;
        logic [1:0]              status;
    } bcf_out_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic init;   // copy control point into working value
        logic step;   // start one interpolation level
    } bcf_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bezier_curve_flattener.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_flattener
// Flattens a Bezier curve given as Q16.8 control points into SEGMENTS line
// segments in integer pixels, using a row of de Casteljau cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one control point word per handshake; last_point ends a curve.
//   Points are taken one per cycle while the block is loading. The first
//   MAX_POINTS points are kept, later ones are dropped and the curve's results
//   carry the dropped status.
//   m_ channel: SEGMENTS segment words per curve, the last one marked final;
//   a curve of fewer than two points gives one word with the too-few status.
//   Sequence: for n control points, each curve point is made by restarting
//   the cells, then running n-1 levels through the three-stage interpolator
//   of every cell, then taking the point; a curve evaluates SEGMENTS + 1
//   points. A too-few word is registered from its own state once the output
//   register is free. s_ready stays low from the last point until the final
//   segment word is registered; points of the next curve are taken while it
//   still waits on m_.
//   Reset empties the point count and the output register.
//   When the output register holds a word and m_ready is low, the sequencer
//   holds at the finished curve point until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_curve_flattener
    import bcf_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int SEGMENTS   = 20
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire bcf_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output bcf_out_t      m_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(SEGMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(MIN_POINTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SEGMENTS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FEW,
        ST_INIT,
        ST_ISSUE,
        ST_WAIT,
        ST_POINT
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      ovf_reg;
    logic [CNT_W-1:0]          npts_reg;
    logic [CNT_W-1:0]          pass_reg;
    logic [1:0]                st_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [PIX_W-1:0]   last_x_reg, last_y_reg;
    logic                      m_valid_reg;
    bcf_out_t                  m_data_reg;

    logic                      s_accept;
    logic                      store_full;
    logic [CNT_W-1:0]          cnt_after;
    logic                      out_free;
    logic                      out_load;
    logic                      pass_done;
    logic signed [PIX_W-1:0]   pix_x, pix_y;
    bcf_cell_ctrl_t            cell_ctrl;

    logic signed [COORD_W-1:0] w_x [MAX_POINTS];
    logic signed [COORD_W-1:0] w_y [MAX_POINTS];
    logic [MAX_POINTS-1:0]     done_vec;

    // Truncate a Q16.8 value toward zero into an integer pixel
    function automatic logic signed [PIX_W-1:0] to_pix(input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W:0] adj;
        adj = {v[COORD_W-1], v}
            + (v[COORD_W-1] ? (COORD_W+1)'((1 << PIX_FRAC) - 1) : (COORD_W+1)'(0));
        return adj[PIX_W+PIX_FRAC-1:PIX_FRAC];
    endfunction

    assign s_ready    = (state_reg == ST_LOAD);
    assign s_accept   = s_valid && s_ready;
    assign store_full = (cnt_reg == CNT_FULL);
    assign cnt_after  = store_full ? cnt_reg : (cnt_reg + CNT_W'(1));
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = out_free && ((state_reg == ST_FEW) ||
                                     ((state_reg == ST_POINT) && (idx_reg != '0)));
    assign pass_done  = &done_vec;
    assign pix_x      = to_pix(w_x[0]);
    assign pix_y      = to_pix(w_y[0]);

    // Broadcast cell control
    always_comb begin
        cell_ctrl      = '0;
        cell_ctrl.init = (state_reg == ST_INIT);
        cell_ctrl.step = (state_reg == ST_ISSUE);
    end

    // Row of cells, each fed by its right neighbor; the last one by itself
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        logic signed [COORD_W-1:0] nb_x, nb_y;
        logic                      load_en;

        if (k == MAX_POINTS - 1) begin : g_end
            assign nb_x = w_x[k];
            assign nb_y = w_y[k];
        end else begin : g_mid
            assign nb_x = w_x[k+1];
            assign nb_y = w_y[k+1];
        end

        assign load_en = s_accept && (cnt_reg == CNT_W'(k));

        bcf_cell #(.SEGMENTS(SEGMENTS)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .load_en (load_en),
            .load_x  (s_data.x_coord),
            .load_y  (s_data.y_coord),
            .nb_x    (nb_x),
            .nb_y    (nb_y),
            .idx     (idx_reg),
            .w_x     (w_x[k]),
            .w_y     (w_y[k]),
            .done    (done_vec[k])
        );
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // Load a new word, or drop valid once the word is taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        if (s_data.last_point) begin
                            cnt_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            npts_reg  <= cnt_after;
                            st_reg    <= (ovf_reg || store_full) ? STATUS_DROP : STATUS_OK;
                            idx_reg   <= '0;
                            state_reg <= (cnt_after < CNT_MIN) ? ST_FEW : ST_INIT;
                        end else begin
                            cnt_reg <= cnt_after;
                            if (store_full) begin
                                ovf_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_FEW: begin
                    if (out_free) begin
                        m_data_reg.start_x       <= '0;
                        m_data_reg.start_y       <= '0;
                        m_data_reg.end_x         <= '0;
                        m_data_reg.end_y         <= '0;
                        m_data_reg.segment_index <= '0;
                        m_data_reg.final_segment <= 1'b1;
                        m_data_reg.status        <= STATUS_FEW;
                        state_reg                <= ST_LOAD;
                    end
                end
                ST_INIT: begin
                    pass_reg  <= npts_reg - CNT_W'(1);
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    pass_reg  <= pass_reg - CNT_W'(1);
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (pass_done) begin
                        state_reg <= (pass_reg == '0) ? ST_POINT : ST_ISSUE;
                    end
                end
                ST_POINT: begin
                    if (idx_reg == '0) begin
                        last_x_reg <= pix_x;
                        last_y_reg <= pix_y;
                        idx_reg    <= IDX_W'(1);
                        state_reg  <= ST_INIT;
                    end else if (out_free) begin
                        m_data_reg.start_x       <= last_x_reg;
                        m_data_reg.start_y       <= last_y_reg;
                        m_data_reg.end_x         <= pix_x;
                        m_data_reg.end_y         <= pix_y;
                        m_data_reg.segment_index <= SEG_IDX_W'(idx_reg);
                        m_data_reg.final_segment <= (idx_reg == IDX_LAST);
                        m_data_reg.status        <= st_reg;
                        last_x_reg               <= pix_x;
                        last_y_reg               <= pix_y;
                        if (idx_reg == IDX_LAST) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_INIT;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/bcf_lerp.sv =====
// ----------------------------------------------------------------------------
// bcf_lerp
// Pipelined interpolator: res = a + trunc((b - a) * idx / SEGMENTS).
// Three register stages; the quotient uses a reciprocal and one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module bcf_lerp
    import bcf_pkg::*;
#(
    parameter  int SEGMENTS = 20,
    localparam int IDX_W    = $clog2(SEGMENTS + 1)
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    input  wire logic signed [COORD_W-1:0] a,
    input  wire logic signed [COORD_W-1:0] b,
    input  wire logic [IDX_W-1:0]          idx,
    output logic                           out_valid,
    output logic signed [COORD_W-1:0]      res
);

    // |b - a| never exceeds 2^24 - 1, so the magnitude keeps COORD_W bits
    localparam int MAG_W   = COORD_W;
    localparam int PROD_W  = MAG_W + IDX_W;
    localparam int RECIP_W = PROD_W + 1;
    localparam int WIDE_W  = PROD_W + RECIP_W;
    localparam longint unsigned RECIP_VAL = (longint'(1) << PROD_W) / longint'(SEGMENTS);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_VAL);
    localparam logic [PROD_W-1:0]  SEG_P  = PROD_W'(SEGMENTS);

    logic signed [COORD_W:0]     diff;
    logic [MAG_W-1:0]            mag;
    logic [WIDE_W-1:0]           wide;
    logic [PROD_W-1:0]           back;
    logic [PROD_W-1:0]           rem;
    logic                        corr;
    logic signed [COORD_W:0]     a_ext;
    logic signed [COORD_W:0]     q_ext;
    logic signed [COORD_W:0]     sum;

    logic                        v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0]           prod1_reg, prod2_reg;
    logic                        neg1_reg, neg2_reg, neg3_reg;
    logic signed [COORD_W-1:0]   a1_reg, a2_reg, a3_reg;
    logic [MAG_W-1:0]            est2_reg;
    logic [MAG_W-1:0]            q3_reg;

    // Stage 1: difference, magnitude and product with the index
    always_comb begin
        diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
        mag  = diff[COORD_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
    end

    // Stage 2: quotient estimate, low by at most one
    assign wide = WIDE_W'(prod1_reg) * WIDE_W'(RECIP);

    // Stage 3: remainder check and correction
    always_comb begin
        back = PROD_W'(est2_reg) * SEG_P;
        rem  = prod2_reg - back;
        corr = (rem >= SEG_P);
    end

    // Output: apply sign and add to the start value
    always_comb begin
        a_ext = {a3_reg[COORD_W-1], a3_reg};
        q_ext = {1'b0, q3_reg};
        sum   = neg3_reg ? (a_ext - q_ext) : (a_ext + q_ext);
    end

    assign res       = sum[COORD_W-1:0];
    assign out_valid = v3_reg;

    // Advance the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        prod1_reg <= PROD_W'(mag) * PROD_W'(idx);
        neg1_reg  <= diff[COORD_W];
        a1_reg    <= a;
        est2_reg  <= wide[PROD_W +: MAG_W];
        prod2_reg <= prod1_reg;
        neg2_reg  <= neg1_reg;
        a2_reg    <= a1_reg;
        q3_reg    <= est2_reg + MAG_W'(corr);
        neg3_reg  <= neg2_reg;
        a3_reg    <= a2_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/bcf_cell.sv =====
// ----------------------------------------------------------------------------
// bcf_cell
// One cell of the de Casteljau row: holds one control point and its working
// value, and interpolates the working value toward its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module bcf_cell
    import bcf_pkg::*;
#(
    parameter  int SEGMENTS = 20,
    localparam int IDX_W    = $clog2(SEGMENTS + 1)
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire bcf_cell_ctrl_t            ctrl,
    input  wire logic                      load_en,
    input  wire logic signed [COORD_W-1:0] load_x,
    input  wire logic signed [COORD_W-1:0] load_y,
    input  wire logic signed [COORD_W-1:0] nb_x,
    input  wire logic signed [COORD_W-1:0] nb_y,
    input  wire logic [IDX_W-1:0]          idx,
    output logic signed [COORD_W-1:0]      w_x,
    output logic signed [COORD_W-1:0]      w_y,
    output logic                           done
);

    logic signed [COORD_W-1:0] pt_x_reg, pt_y_reg;
    logic signed [COORD_W-1:0] w_x_reg, w_y_reg;
    logic signed [COORD_W-1:0] res_x, res_y;
    logic                      done_x, done_y;

    bcf_lerp #(.SEGMENTS(SEGMENTS)) u_lerp_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ctrl.step),
        .a         (w_x_reg),
        .b         (nb_x),
        .idx       (idx),
        .out_valid (done_x),
        .res       (res_x)
    );

    bcf_lerp #(.SEGMENTS(SEGMENTS)) u_lerp_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ctrl.step),
        .a         (w_y_reg),
        .b         (nb_y),
        .idx       (idx),
        .out_valid (done_y),
        .res       (res_y)
    );

    // Hold the control point; restart or advance the working value
    always_ff @(posedge aclk) begin
        if (load_en) begin
            pt_x_reg <= load_x;
            pt_y_reg <= load_y;
        end
        if (ctrl.init) begin
            w_x_reg <= pt_x_reg;
            w_y_reg <= pt_y_reg;
        end else begin
            if (done_x) begin
                w_x_reg <= res_x;
            end
            if (done_y) begin
                w_y_reg <= res_y;
            end
        end
    end

    assign w_x  = w_x_reg;
    assign w_y  = w_y_reg;
    assign done = done_x & done_y;

endmodule

`default_nettype wire

// ===== rtl/bcf_checker.sv =====
// ----------------------------------------------------------------------------
// bcf_checker
// Port-level checks of the Bezier curve flattener, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bezier_curve_flattener_defines.svh"

module bcf_checker
    import bcf_pkg::*;
#(
    parameter int SEGMENTS = 20
) (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire bcf_out_t m_data
);

    // A stalled result word holds
    `BCF_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // A too-few word is alone and carries no segment
    `BCF_ASSERT_NOW(a_few_form, aclk, aresetn, m_valid && (m_data.status == STATUS_FEW), m_data.final_segment && (m_data.segment_index == '0), "malformed too-few word")

    // Segment indexes stay within one curve
    `BCF_ASSERT_NOW(a_idx_range, aclk, aresetn, m_valid && (m_data.status != STATUS_FEW), (m_data.segment_index != '0) && (m_data.segment_index <= 7'(SEGMENTS)), "segment index out of range")

    // Only the last segment is marked final
    `BCF_ASSERT_NOW(a_final_idx, aclk, aresetn, m_valid && m_data.final_segment && (m_data.status != STATUS_FEW), m_data.segment_index == 7'(SEGMENTS), "final mark on wrong segment")

    // No new points while a curve is still being drawn
    `BCF_ASSERT_NOW(a_busy_load, aclk, aresetn, m_valid && !m_data.final_segment, !s_ready, "input taken during curve evaluation")

endmodule

bind bezier_curve_flattener bcf_checker #(
    .SEGMENTS(SEGMENTS)
) u_bcf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
